[hw/rtl/atomic_memory_op_unit_core_macros.svh]
// assertion macros shared by the atomic memory op unit rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ATOMIC_MEMORY_OP_UNIT_CORE_MACROS_SVH
`define ATOMIC_MEMORY_OP_UNIT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AMOU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("amou assertion failed");
`define AMOU_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("amou forbidden condition");
`else
`define AMOU_ASSERT(lbl, clk, rstn, prop)
`define AMOU_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hw/rtl/amou_pkg.sv]
// types, codes and helpers of the atomic memory op unit
// no dependencies
`timescale 1ns / 1ps
package amou_pkg;

    localparam logic [4:0] OP_MIN   = 5'd0;
    localparam logic [4:0] OP_MAX   = 5'd1;
    localparam logic [4:0] OP_SUM   = 5'd2;
    localparam logic [4:0] OP_PROD  = 5'd3;
    localparam logic [4:0] OP_LOR   = 5'd4;
    localparam logic [4:0] OP_LAND  = 5'd5;
    localparam logic [4:0] OP_BOR   = 5'd6;
    localparam logic [4:0] OP_BAND  = 5'd7;
    localparam logic [4:0] OP_LXOR  = 5'd8;
    localparam logic [4:0] OP_BXOR  = 5'd9;
    localparam logic [4:0] OP_READ  = 5'd10;
    localparam logic [4:0] OP_WRITE = 5'd11;
    localparam logic [4:0] OP_CSEQ  = 5'd12;
    localparam logic [4:0] OP_CSNE  = 5'd13;
    localparam logic [4:0] OP_CSLE  = 5'd14;
    localparam logic [4:0] OP_CSLT  = 5'd15;
    localparam logic [4:0] OP_CSGE  = 5'd16;
    localparam logic [4:0] OP_CSGT  = 5'd17;
    localparam logic [4:0] OP_MSWAP = 5'd18;

    localparam logic [3:0] DT_LAST_INT = 4'd7;

    typedef struct packed {
        logic [4:0]  op;
        logic [3:0]  datatype;
        logic [9:0]  addr;
        logic [63:0] operand;
        logic [63:0] compare;
        logic        last_element;
        logic        unsup;
    } item_t;

    // lane mask for an integer datatype code
    function automatic logic [63:0] lane_mask(input logic [3:0] dt);
        logic [63:0] m;
        case (dt[2:1])
            2'd0:    m = 64'h0000_0000_0000_00ff;
            2'd1:    m = 64'h0000_0000_0000_ffff;
            2'd2:    m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/amou_ram.sv]
// generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module amou_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hw/rtl/amou_front.sv]
// front end: takes commands and classifies them as supported or not
// depends on amou_pkg
`timescale 1ns / 1ps
module amou_front (
    input  logic                start,
    input  logic                full,
    input  logic [4:0]          op,
    input  logic [3:0]          datatype,
    input  logic                fetch,
    input  logic [9:0]          addr,
    input  logic [63:0]         operand,
    input  logic [63:0]         compare,
    input  logic                last_element,
    output logic                busy,
    output logic                push,
    output amou_pkg::item_t     item
);
    import amou_pkg::*;

    assign busy = full;
    assign push = start && !full;

    always_comb
    begin
        item.op           = op;
        item.datatype     = datatype;
        item.addr         = addr;
        item.operand      = operand;
        item.compare      = compare;
        item.last_element = last_element;
        // read without fetch, bad op or non-integer type
        item.unsup        = (op > OP_MSWAP) || (datatype > DT_LAST_INT)
                            || ((op == OP_READ) && !fetch);
    end
endmodule

[hw/rtl/amou_fifo.sv]
// two entry queue between front and back end
// depends on amou_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "atomic_memory_op_unit_core_macros.svh"
module amou_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  amou_pkg::item_t din,
    input  logic            pop,
    output amou_pkg::item_t dout,
    output logic            empty,
    output logic            full
);
    import amou_pkg::*;

    item_t      ent_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign dout  = ent_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= din;
        end
    end

    `AMOU_NEVER(a_no_push_full, clk, rst_n, push && full)
    `AMOU_NEVER(a_no_pop_empty, clk, rst_n, pop && empty)
    `AMOU_ASSERT(a_cnt_up, clk, rst_n, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
endmodule

[hw/rtl/amou_back.sv]
// back end: address wrap, memory read, operation, write back, result
// depends on amou_pkg, amou_ram and the assertion macro header
`timescale 1ns / 1ps
`include "atomic_memory_op_unit_core_macros.svh"
module amou_back #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  amou_pkg::item_t head,
    input  logic            empty,
    output logic            pop,
    output logic            done,
    output logic [63:0]     old_value,
    output logic            status,
    output logic            end_of_run
);
    import amou_pkg::*;

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam bit NEED_MOD = (MEM_DEPTH < 1024);

    localparam logic [9:0]  DMOD  = NEED_MOD ? 10'(MEM_DEPTH) : 10'd1;
    // floor(2^20 / depth): the quotient estimate is exact or one low
    localparam logic [20:0] RECIP = NEED_MOD ? 21'((1 << 20) / MEM_DEPTH) : 21'd0;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_ISS  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_WR   = 3'd6;
    localparam logic [2:0] S_FIX  = 3'd7;

    logic [2:0]  state_reg, state_next;
    item_t       it_reg, it_next;
    logic [9:0]  idx_reg, idx_next;
    logic [9:0]  quo_reg, quo_next;
    logic [63:0] word_reg, word_next;
    logic [63:0] n_reg, n_next;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic        done_reg, done_next;
    logic [63:0] old_reg, old_next;
    logic        stat_reg, stat_next;
    logic        eor_reg, eor_next;

    logic [63:0] rdata, m, sb, d, s, c, kd, ks, kc, nv;
    logic        re, we;
    logic [30:0] qprod;
    logic [19:0] qd;
    logic [9:0]  rem;

    assign m  = lane_mask(it_reg.datatype);
    assign sb = it_reg.datatype[0] ? 64'd0 : (m ^ (m >> 1));
    assign d  = word_reg & m;
    assign s  = it_reg.operand & m;
    assign c  = it_reg.compare & m;
    assign kd = d ^ sb;
    assign ks = s ^ sb;
    assign kc = c ^ sb;

    assign qprod = {21'd0, idx_reg} * {10'd0, RECIP};
    assign qd    = {10'd0, quo_reg} * {10'd0, DMOD};
    assign rem   = idx_reg - qd[9:0];

    assign pop = (state_reg == S_IDLE) && !empty;
    assign re  = (state_reg == S_ISS);
    assign we  = (state_reg == S_WR);

    always_comb
    begin
        nv = d;
        case (it_reg.op)
            OP_MIN:   nv = (kd > ks) ? s : d;
            OP_MAX:   nv = (kd < ks) ? s : d;
            OP_SUM:   nv = d + s;
            OP_LOR:   nv = {63'd0, (d != 64'd0) || (s != 64'd0)};
            OP_LAND:  nv = {63'd0, (d != 64'd0) && (s != 64'd0)};
            OP_BOR:   nv = d | s;
            OP_BAND:  nv = d & s;
            OP_LXOR:  nv = {63'd0, (d != 64'd0) != (s != 64'd0)};
            OP_BXOR:  nv = d ^ s;
            OP_WRITE: nv = s;
            OP_CSEQ:  nv = (kd == kc) ? s : d;
            OP_CSNE:  nv = (kd != kc) ? s : d;
            OP_CSLE:  nv = (kd <= kc) ? s : d;
            OP_CSLT:  nv = (kd < kc) ? s : d;
            OP_CSGE:  nv = (kd >= kc) ? s : d;
            OP_CSGT:  nv = (kd > kc) ? s : d;
            OP_MSWAP: nv = (s & c) | (d & ~c);
            default:  nv = d;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        idx_next   = idx_reg;
        quo_next   = quo_reg;
        word_next  = word_reg;
        n_next     = n_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        done_next  = 1'b0;
        old_next   = old_reg;
        stat_next  = stat_reg;
        eor_next   = eor_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    it_next  = head;
                    idx_next = head.addr;
                    if (head.unsup)
                    begin
                        done_next = 1'b1;
                        old_next  = 64'd0;
                        stat_next = 1'b1;
                        eor_next  = head.last_element;
                    end
                    else
                    begin
                        state_next = NEED_MOD ? S_MOD : S_ISS;
                    end
                end
            end
            S_MOD:
            begin
                // quotient estimate by reciprocal multiply
                quo_next   = qprod[29:20];
                state_next = S_FIX;
            end
            S_FIX:
            begin
                // remainder, at most one correction step
                idx_next   = (rem >= DMOD) ? (rem - DMOD) : rem;
                state_next = S_ISS;
            end
            S_ISS:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                word_next  = rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                n_next  = nv;
                p0_next = {32'd0, d[31:0]} * {32'd0, s[31:0]};
                p1_next = d[31:0] * s[63:32];
                p2_next = d[63:32] * s[31:0];
                state_next = (it_reg.op == OP_PROD) ? S_MUL : S_WR;
            end
            S_MUL:
            begin
                n_next     = p0_reg + {p1_reg + p2_reg, 32'd0};
                state_next = S_WR;
            end
            S_WR:
            begin
                done_next  = 1'b1;
                old_next   = word_reg;
                stat_next  = 1'b0;
                eor_next   = it_reg.last_element;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        idx_reg  <= idx_next;
        quo_reg  <= quo_next;
        word_reg <= word_next;
        n_reg    <= n_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        old_reg  <= old_next;
        stat_reg <= stat_next;
        eor_reg  <= eor_next;
    end

    amou_ram #(
        .WIDTH (64),
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(idx_reg)),
        .wdata ((word_reg & ~m) | (n_reg & m)),
        .re    (re),
        .raddr (AW'(idx_reg)),
        .rdata (rdata)
    );

    assign done       = done_reg;
    assign old_value  = old_reg;
    assign status     = stat_reg;
    assign end_of_run = eor_reg;

    `AMOU_ASSERT(a_wr_done, clk, rst_n, (state_reg == S_WR) |=> done_reg)
    `AMOU_ASSERT(a_unsup_zero, clk, rst_n, (done_reg && stat_reg) |-> (old_reg == 64'd0))
    `AMOU_NEVER(a_pop_busy, clk, rst_n, pop && (state_reg != S_IDLE))
endmodule

[hw/rtl/atomic_memory_op_unit_core.sv]
// top level of the atomic memory op unit: front end, queue, back end
// depends on amou_pkg, amou_front, amou_fifo, amou_back, amou_ram
`timescale 1ns / 1ps
// a command is taken at a rising edge with start high and busy low; busy only
// rises when the two-beat queue between front and back end is full. every
// command returns exactly one result beat, shown for one cycle with done high,
// in command order; the receiver cannot stall it. the back end handles one
// command at a time: a supported command goes through read issue, read data,
// execute and write back, then the result beat is registered; product adds
// the split 64-bit multiply step, and when MEM_DEPTH is below 1024 the address
// wrap adds a reciprocal multiply for the quotient, then subtract and one
// correction; an unsupported command is answered from the dequeue alone. the
// target memory has no reset: a word must be written before it is read.
module atomic_memory_op_unit_core #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  op,
    input  logic [3:0]  datatype,
    input  logic        fetch,
    input  logic [9:0]  addr,
    input  logic [63:0] operand,
    input  logic [63:0] compare,
    input  logic        last_element,
    output logic        done,
    output logic [63:0] old_value,
    output logic        status,
    output logic        end_of_run
);
    import amou_pkg::*;

    item_t fe_item;
    item_t q_head;
    logic  fe_push;
    logic  q_full;
    logic  q_empty;
    logic  be_pop;

    // classify at the door
    amou_front u_front (
        .start        (start),
        .full         (q_full),
        .op           (op),
        .datatype     (datatype),
        .fetch        (fetch),
        .addr         (addr),
        .operand      (operand),
        .compare      (compare),
        .last_element (last_element),
        .busy         (busy),
        .push         (fe_push),
        .item         (fe_item)
    );

    // decouples acceptance from execution
    amou_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .din   (fe_item),
        .pop   (be_pop),
        .dout  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    // read-modify-write on the target memory
    amou_back #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .empty      (q_empty),
        .pop        (be_pop),
        .done       (done),
        .old_value  (old_value),
        .status     (status),
        .end_of_run (end_of_run)
    );
endmodule

[sim/tb_atomic_memory_op_unit_core.sv]
// testbench of the atomic memory op unit: directed and random command beats,
// predicted against an own model of the target memory; depends on amou_pkg
`timescale 1ns / 1ps
module tb_atomic_memory_op_unit_core;
    import amou_pkg::*;

    // datatype codes as seen on the port
    typedef enum logic [3:0] {
        DT_I8 = 4'd0, DT_U8 = 4'd1, DT_I16 = 4'd2, DT_U16 = 4'd3,
        DT_I32 = 4'd4, DT_U32 = 4'd5, DT_I64 = 4'd6, DT_U64 = 4'd7,
        DT_F32 = 4'd8, DT_CPLX = 4'd13
    } dtype_e;

    localparam int IDLE_LIMIT = 4000;
    localparam int POOL_SIZE  = 40;

    typedef struct packed {
        logic [63:0] old_value;
        logic        status;
        logic        end_of_run;
    } amo_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  op;
    logic [3:0]  datatype;
    logic        fetch;
    logic [9:0]  addr;
    logic [63:0] operand;
    logic [63:0] compare;
    logic        last_element;
    logic        done;
    logic [63:0] old_value;
    logic        status;
    logic        end_of_run;

    // shadow of the target memory and which words have been written
    logic [63:0] shadow_mem [1024];
    logic        word_valid [1024];
    logic [9:0]  addr_pool [POOL_SIZE];

    amo_result_t pending_results[$];
    int          mismatches;
    int          beats_sent;
    int          results_seen;
    int          idle_cycles;

    atomic_memory_op_unit_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .datatype     (datatype),
        .fetch        (fetch),
        .addr         (addr),
        .operand      (operand),
        .compare      (compare),
        .last_element (last_element),
        .done         (done),
        .old_value    (old_value),
        .status       (status),
        .end_of_run   (end_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // apply one atomic op to the shadow memory and return what the unit must answer
    function automatic amo_result_t amo_apply(input logic [4:0] c_op, input logic [3:0] c_dt,
                                              input logic c_fetch, input logic [9:0] c_addr,
                                              input logic [63:0] c_src,
                                              input logic [63:0] c_cmp, input logic c_last);
        amo_result_t r;
        logic [63:0] m, word, d, s, c, n, sb, kd, ks, kc;
        int          bits;
        r.old_value  = 64'd0;
        r.status     = 1'b1;
        r.end_of_run = c_last;
        if (c_op > OP_MSWAP || c_dt > DT_LAST_INT || (c_op == OP_READ && !c_fetch))
            return r;
        bits = 8 << c_dt[2:1];
        m    = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        sb   = c_dt[0] ? 64'd0 : (64'd1 << (bits - 1));
        word = shadow_mem[c_addr];
        d = word & m;
        s = c_src & m;
        c = c_cmp & m;
        // flipping the sign bit turns a signed order into an unsigned one
        kd = d ^ sb;
        ks = s ^ sb;
        kc = c ^ sb;
        n  = d;
        case (c_op)
            OP_MIN:   if (kd > ks) n = s;
            OP_MAX:   if (kd < ks) n = s;
            OP_SUM:   n = d + s;
            OP_PROD:  n = d * s;
            OP_LOR:   n = (d != 0 || s != 0) ? 64'd1 : 64'd0;
            OP_LAND:  n = (d != 0 && s != 0) ? 64'd1 : 64'd0;
            OP_BOR:   n = d | s;
            OP_BAND:  n = d & s;
            OP_LXOR:  n = ((d != 0) != (s != 0)) ? 64'd1 : 64'd0;
            OP_BXOR:  n = d ^ s;
            OP_READ:  n = d;
            OP_WRITE: n = s;
            OP_CSEQ:  if (kd == kc) n = s;
            OP_CSNE:  if (kd != kc) n = s;
            OP_CSLE:  if (kd <= kc) n = s;
            OP_CSLT:  if (kd < kc) n = s;
            OP_CSGE:  if (kd >= kc) n = s;
            OP_CSGT:  if (kd > kc) n = s;
            default:  n = (s & c) | (d & ~c);
        endcase
        shadow_mem[c_addr] = (word & ~m) | (n & m);
        r.old_value = word;
        r.status    = 1'b0;
        return r;
    endfunction

    // send one command beat after a random gap, predict once it is taken
    task automatic send_cmd(input logic [4:0] c_op, input logic [3:0] c_dt,
                            input logic c_fetch, input logic [9:0] c_addr,
                            input logic [63:0] c_src, input logic [63:0] c_cmp,
                            input logic c_last);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        op           <= c_op;
        datatype     <= c_dt;
        fetch        <= c_fetch;
        addr         <= c_addr;
        operand      <= c_src;
        compare      <= c_cmp;
        last_element <= c_last;
        // values read right after the edge are the ones the unit sampled
        do @(posedge clk); while (!(start && !busy));
        pending_results.push_back(amo_apply(c_op, c_dt, c_fetch, c_addr, c_src, c_cmp, c_last));
        if (!(c_op > OP_MSWAP || c_dt > DT_LAST_INT || (c_op == OP_READ && !c_fetch)))
            word_valid[c_addr] = 1'b1;
        beats_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // random 64-bit value biased toward the lane edges
    function automatic logic [63:0] edge_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'd1 << (8 << $urandom_range(0, 3)) - 1;
            3: v = (64'd1 << (8 << $urandom_range(0, 2))) - 1;
            4: v = {$urandom, $urandom} & 64'hff;
            default: ;
        endcase
        return v;
    endfunction

    // extremes, every op, each kind of unsupported command
    task automatic test_directed();
        logic [4:0] o;
        for (int i = 0; i < 4; i++)
            send_cmd(OP_WRITE, DT_U64, 1'b0, addr_pool[i],
                     (i == 1) ? '1 : {$urandom, $urandom}, 64'd0, 1'b0);
        send_cmd(OP_WRITE, DT_I64, 1'b1, 10'd1023, 64'h8000_0000_0000_0000, '1, 1'b1);
        for (int k = 0; k <= OP_MSWAP; k++)
        begin
            o = k[4:0];
            send_cmd(o, dtype_e'(k % 8), k[0], addr_pool[k % 4], edge_value(), edge_value(),
                     k[1]);
        end
        // read without fetch, op codes past the last, non-integer types
        send_cmd(OP_READ, DT_U64, 1'b0, addr_pool[0], '1, '1, 1'b1);
        send_cmd(5'd19, DT_U32, 1'b1, addr_pool[1], '1, '1, 1'b0);
        send_cmd(5'd31, DT_I8, 1'b1, addr_pool[2], '1, '1, 1'b1);
        send_cmd(OP_SUM, DT_F32, 1'b1, 10'd1023, '1, '1, 1'b0);
        send_cmd(OP_MIN, DT_CPLX, 1'b0, 10'd0, 64'd0, 64'd0, 1'b1);
    endtask

    task automatic test_random(input int count);
        logic [4:0]  o;
        logic [3:0]  t;
        logic [9:0]  a;
        logic [63:0] s, c, m;
        for (int i = 0; i < count; i++)
        begin
            a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            o = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(19, 31))
                                             : 5'($urandom_range(0, 18));
            t = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(8, 13))
                                             : 4'($urandom_range(0, 7));
            s = edge_value();
            c = edge_value();
            m = (64'd1 << (8 << t[2:1])) - 1;
            // equal compares need the current lane value
            if ($urandom_range(0, 2) == 0 && t <= DT_LAST_INT)
                c = shadow_mem[a] ^ {$urandom, $urandom} & ~m;
            // a word never written must get a full-width write first
            if (!word_valid[a] && o <= OP_MSWAP && t <= DT_LAST_INT)
            begin
                o = OP_WRITE;
                t = $urandom_range(0, 1) ? DT_U64 : DT_I64;
            end
            send_cmd(o, t, 1'($urandom), a, s, c, 1'($urandom));
        end
    endtask

    // every result beat is checked against the oldest prediction
    always @(posedge clk)
    begin
        amo_result_t exp_r;
        if (done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat old=%h status=%b eor=%b",
                             old_value, status, end_of_run);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (old_value !== exp_r.old_value || status !== exp_r.status ||
                    end_of_run !== exp_r.end_of_run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp old=%h st=%b eor=%b got old=%h st=%b eor=%b",
                                 exp_r.old_value, exp_r.status, exp_r.end_of_run,
                                 old_value, status, end_of_run);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = '0;
        datatype     = '0;
        fetch        = 1'b0;
        addr         = '0;
        operand      = '0;
        compare      = '0;
        last_element = 1'b0;
        mismatches   = 0;
        beats_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        for (int i = 0; i < 1024; i++)
        begin
            shadow_mem[i] = 64'd0;
            word_valid[i] = 1'b0;
        end
        addr_pool[0] = 10'd0;
        addr_pool[1] = 10'd1023;
        addr_pool[2] = 10'h155;
        addr_pool[3] = 10'h2aa;
        for (int i = 4; i < POOL_SIZE; i++)
            addr_pool[i] = 10'($urandom_range(0, 1023));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(560);
        drain_results();
        test_random(570);
        drain_results();
        repeat (30) @(posedge clk);

        $display("sent %0d command beats, checked %0d result beats, %0d mismatches",
                 beats_sent, results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
